### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the grid upsampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

### hw/rtl/gsu_pkg.sv
// ----------------------------------------------------------------------------
// gsu_pkg
// Types and fixed constants of the grid linear upsampler.
// ----------------------------------------------------------------------------
package gsu_pkg;

  localparam int ROW_W       = 6;
  localparam int COL_W       = 6;
  localparam int HEIGHT_W    = 8;
  localparam int STATUS_W    = 2;
  localparam int CFG_W       = 4;
  localparam int COUNT_VALUES = 2 ** CFG_W;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_W-1:0] COUNT_RESET = 4'd5;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ADDR    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SPACING = 2'd2;

  typedef struct packed {
    logic                command;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [HEIGHT_W-1:0] height;
  } gsu_in_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height_out;
    logic [STATUS_W-1:0] status;
  } gsu_out_t;

  // Work class decided by the front end
  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_READ,
    KIND_ERR_ADDR,
    KIND_ERR_SPACING
  } gsu_kind_e;

  typedef struct packed {
    gsu_kind_e           kind;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [HEIGHT_W-1:0] height;
  } gsu_job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_ROW,
    ST_DIV_COL,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_LERP,
    ST_VALUE,
    ST_FINISH
  } gsu_state_e;

  // Which segment is being interpolated
  typedef enum logic [1:0] {
    STAGE_TOP,
    STAGE_BOT,
    STAGE_VERT
  } gsu_stage_e;

  typedef struct packed {
    logic busy;
    logic done;
  } gsu_div_stat_t;

endpackage

### hw/rtl/gsu_ram.sv
// ----------------------------------------------------------------------------
// gsu_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module gsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 81
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/gsu_div.sv
// ----------------------------------------------------------------------------
// gsu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsu_div #(
  parameter int NUM_W = 15,
  parameter int DEN_W = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic [DEN_W-1:0]       den_i,
  output gsu_pkg::gsu_div_stat_t stat_o,
  output logic [NUM_W-1:0]       quot_o,
  output logic [DEN_W-1:0]       rem_o
);
  import gsu_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_d  = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
    quo_d  = {quo_q[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

### hw/rtl/gsu_queue.sv
// ----------------------------------------------------------------------------
// gsu_queue
// Short job queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsu_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gsu_pkg::gsu_job_t job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output gsu_pkg::gsu_job_t job_o
);
  import gsu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  gsu_job_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PTR_W'(1);
      if (pop_i)  rptr_q <= rptr_q + PTR_W'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= job_i;
  end

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign job_o   = mem_q[rptr_q];

  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, pop_i && (count_q == '0), "pop from empty queue")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && full_o && !pop_i, "push into full queue")

endmodule

### hw/rtl/gsu_front.sv
// ----------------------------------------------------------------------------
// gsu_front
// Input transfer, count register and classification of each item.
// ----------------------------------------------------------------------------
module gsu_front #(
  parameter int GRID        = 40,
  parameter int CONTROL_MAX = 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gsu_pkg::gsu_in_t                in_data_i,
  input  logic                            cfg_we_i,
  input  logic [gsu_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output gsu_pkg::gsu_job_t               job_o,
  output logic [$clog2(GRID+1)-1:0]       span_o
);
  import gsu_pkg::*;

  localparam int SPAN_W = $clog2(GRID + 1);

  logic [CFG_W-1:0]  count_q;
  logic [SPAN_W-1:0] span_tab [COUNT_VALUES];
  logic              ok_tab   [COUNT_VALUES];
  logic              spacing_ok;

  // span and divisibility for every possible count, fixed at elaboration
  for (genvar k = 0; k < COUNT_VALUES; k++) begin : g_span
    localparam int DIVISOR = (k >= 2) ? (k - 1) : 1;
    localparam bit GOOD = (k >= 2) && (k <= CONTROL_MAX) && ((GRID % DIVISOR) == 0);
    assign span_tab[k] = GOOD ? SPAN_W'(GRID / DIVISOR) : '0;
    assign ok_tab[k]   = GOOD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  assign span_o     = span_tab[count_q];
  assign spacing_ok = ok_tab[count_q];

  always_comb begin
    job_o.row    = in_data_i.row;
    job_o.col    = in_data_i.col;
    job_o.height = in_data_i.height;
    if (in_data_i.command == CMD_LOAD) begin
      if (int'(in_data_i.row) >= CONTROL_MAX || int'(in_data_i.col) >= CONTROL_MAX) begin
        job_o.kind = KIND_ERR_ADDR;
      end else begin
        job_o.kind = KIND_LOAD;
      end
    end else if (int'(in_data_i.row) > GRID || int'(in_data_i.col) > GRID) begin
      job_o.kind = KIND_ERR_ADDR;
    end else if (!spacing_ok) begin
      job_o.kind = KIND_ERR_SPACING;
    end else begin
      job_o.kind = KIND_READ;
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

### hw/rtl/gsu_back.sv
// ----------------------------------------------------------------------------
// gsu_back
// Sequencer: store writes, control point reads, lerp steps, result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsu_back #(
  parameter int GRID        = 40,
  parameter int CONTROL_MAX = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  gsu_pkg::gsu_job_t         q_job_i,
  output logic                      q_pop_o,
  input  logic [$clog2(GRID+1)-1:0] span_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gsu_pkg::gsu_out_t         out_data_o
);
  import gsu_pkg::*;

  localparam int SPAN_W = $clog2(GRID + 1);
  localparam int DIV_W  = SPAN_W + HEIGHT_W + 1;
  localparam int PROD_W = SPAN_W + HEIGHT_W;
  localparam int CI_W   = $clog2(CONTROL_MAX);
  localparam int DEPTH  = CONTROL_MAX * CONTROL_MAX;
  localparam int ADDR_W = $clog2(DEPTH);

  gsu_state_e          state_q, state_d;
  gsu_stage_e          stage_q;
  logic [COL_W-1:0]    col_q;
  logic [CI_W-1:0]     cr_q, cc_q;
  logic [SPAN_W-1:0]   roff_q, coff_q;
  logic [HEIGHT_W-1:0] a_q, b_q, top_q, val_q;
  logic                falling_q;
  logic [DIV_W-1:0]    num_q;
  gsu_out_t            res_q, out_data_q;
  logic                out_valid_q;
  logic                out_load;

  logic                div_start;
  logic [DIV_W-1:0]    div_num, div_quot;
  logic [SPAN_W-1:0]   div_rem;
  gsu_div_stat_t       div_stat;

  logic                ram_we;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [HEIGHT_W-1:0] rdata;

  logic [SPAN_W-1:0]   lerp_i;
  logic [HEIGHT_W-1:0] diff, quot8;
  logic                falling;
  logic [PROD_W-1:0]   prod;
  logic [ADDR_W-1:0]   rd_row, rd_col;

  gsu_ram #(.WIDTH(HEIGHT_W), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (q_job_i.height),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gsu_div #(.NUM_W(DIV_W), .DEN_W(SPAN_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (span_i),
    .stat_o  (div_stat),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // store addresses
  always_comb begin
    waddr  = ADDR_W'(q_job_i.row[CI_W-1:0]) * ADDR_W'(CONTROL_MAX)
           + ADDR_W'(q_job_i.col[CI_W-1:0]);
    rd_row = ADDR_W'(cr_q) + ((stage_q == STAGE_BOT) ? ADDR_W'(1) : ADDR_W'(0));
    rd_col = ADDR_W'(cc_q)
           + (((state_q == ST_RD_B) && (coff_q != '0)) ? ADDR_W'(1) : ADDR_W'(0));
    raddr  = rd_row * ADDR_W'(CONTROL_MAX) + rd_col;
  end

  // lerp operands: multiply here, register, then divide
  always_comb begin
    lerp_i  = (stage_q == STAGE_VERT) ? roff_q : coff_q;
    falling = a_q > b_q;
    diff    = falling ? (a_q - b_q) : (b_q - a_q);
    prod    = PROD_W'(lerp_i) * PROD_W'(diff);
    quot8   = div_quot[HEIGHT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    div_num   = num_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ram_we  = q_job_i.kind == KIND_LOAD;
          if (q_job_i.kind == KIND_READ) begin
            div_start = 1'b1;
            div_num   = DIV_W'(q_job_i.row);
            state_d   = ST_DIV_ROW;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_DIV_ROW: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_num   = DIV_W'(col_q);
          state_d   = ST_DIV_COL;
        end
      end
      ST_DIV_COL: begin
        if (div_stat.done) state_d = ST_RD_A;
      end
      ST_RD_A:      state_d = ST_RD_B;
      ST_RD_B:      state_d = (coff_q == '0) ? ST_VALUE : ST_RD_C;
      ST_RD_C:      state_d = ST_MUL;
      ST_MUL:       state_d = ST_DIV_START;
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_LERP;
      end
      ST_DIV_LERP: begin
        if (div_stat.done) state_d = ST_VALUE;
      end
      ST_VALUE: begin
        unique case (stage_q)
          STAGE_TOP: state_d = (roff_q == '0) ? ST_FINISH : ST_RD_A;
          STAGE_BOT: state_d = ST_MUL;
          default:   state_d = ST_FINISH;
        endcase
      end
      ST_FINISH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        col_q <= q_job_i.col;
        case (q_job_i.kind)
          KIND_ERR_ADDR:    res_q <= '{height_out: '0, status: STATUS_ADDR};
          KIND_ERR_SPACING: res_q <= '{height_out: '0, status: STATUS_SPACING};
          default:          res_q <= '{height_out: '0, status: STATUS_OK};
        endcase
      end
      ST_DIV_ROW: begin
        if (div_stat.done) begin
          cr_q   <= div_quot[CI_W-1:0];
          roff_q <= div_rem;
        end
      end
      ST_DIV_COL: begin
        if (div_stat.done) begin
          cc_q    <= div_quot[CI_W-1:0];
          coff_q  <= div_rem;
          stage_q <= STAGE_TOP;
        end
      end
      ST_RD_B: begin
        a_q   <= rdata;
        val_q <= rdata;
      end
      ST_RD_C: b_q <= rdata;
      ST_MUL: begin
        falling_q <= falling;
        num_q     <= DIV_W'(prod) + (falling ? DIV_W'(span_i - SPAN_W'(1)) : '0);
      end
      ST_DIV_LERP: begin
        if (div_stat.done) val_q <= falling_q ? (a_q - quot8) : (a_q + quot8);
      end
      ST_VALUE: begin
        case (stage_q)
          STAGE_TOP: begin
            top_q <= val_q;
            if (roff_q == '0) begin
              res_q <= '{height_out: val_q, status: STATUS_OK};
            end else begin
              stage_q <= STAGE_BOT;
            end
          end
          STAGE_BOT: begin
            a_q     <= top_q;
            b_q     <= val_q;
            stage_q <= STAGE_VERT;
          end
          default: res_q <= '{height_out: val_q, status: STATUS_OK};
        endcase
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_data_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_NEVER(a_div_restart, clk_i, rst_ni, div_start && div_stat.busy, "divider restarted while busy")
  `ASSERT_CLK(a_err_zero, clk_i, rst_ni, (out_valid_q && (out_data_q.status != STATUS_OK)) |-> (out_data_q.height_out == '0), "error result with nonzero height")
  `ASSERT_CLK(a_load_in_range, clk_i, rst_ni, ram_we |-> ((int'(q_job_i.row) < CONTROL_MAX) && (int'(q_job_i.col) < CONTROL_MAX)), "store write outside control grid")

endmodule

### hw/rtl/grid_linear_upsampler.sv
// ----------------------------------------------------------------------------
// grid_linear_upsampler
// Control height store with bilinear-style reads of a fine grid.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i): command 0 loads a
//   control height at (row, col) of the coarse grid, command 1 reads fine
//   point (row, col) of the (GRID+1) x (GRID+1) grid. Every transfer returns
//   exactly one result on the output channel (out_valid_o / out_ready_i /
//   out_data_o), in order: height_out and status (ok, bad address, spacing).
//   cfg_we_i writes control_count from cfg_data_i; write it only while idle.
// Divider (clog2(GRID+1) + 9 bits wide, 15 at GRID = 40):
//   a load or a flagged item skips it and goes straight to the result;
//   a read runs two divisions for the row and column split and up to
//   three lerp steps (store reads, multiply, divide), one after another
//   on the one shared bit-serial divider.
// Stall: a two-entry job queue keeps taking items until it is full, while the
//   sequencer works and while a finished result waits in the output register.
// Reset: control_count returns to 5, queue and output are emptied; the
//   control store keeps no reset and must be loaded before it is read.
// ----------------------------------------------------------------------------
module grid_linear_upsampler #(
  parameter int GRID        = 40,
  parameter int CONTROL_MAX = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  gsu_pkg::gsu_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output gsu_pkg::gsu_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [gsu_pkg::CFG_W-1:0] cfg_data_i
);
  import gsu_pkg::*;

  localparam int SPAN_W = $clog2(GRID + 1);

  // front to queue
  logic              push;
  gsu_job_t          push_job;
  logic              q_full;
  // queue to sequencer
  logic              q_valid;
  logic              q_pop;
  gsu_job_t          q_job;
  // current control spacing in fine cells
  logic [SPAN_W-1:0] span;

  gsu_front #(.GRID(GRID), .CONTROL_MAX(CONTROL_MAX)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (push_job),
    .span_o     (span)
  );

  gsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // sequencer owns the control store, the divider and the output register
  gsu_back #(.GRID(GRID), .CONTROL_MAX(CONTROL_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job),
    .q_pop_o     (q_pop),
    .span_i      (span),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sim/gsu_height_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsu_height_checker
// Watches the upsampler's channels, predicts every result and compares it.
// ----------------------------------------------------------------------------
module gsu_height_checker #(
  parameter int GRID        = 40,
  parameter int CONTROL_MAX = 9
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  gsu_pkg::gsu_in_t          in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  gsu_pkg::gsu_out_t         out_data_i,
  input  logic                      cfg_we_i,
  input  logic [gsu_pkg::CFG_W-1:0] cfg_data_i,
  output int                        mismatch_count_o,
  output int                        pending_o
);
  import gsu_pkg::*;

  localparam int STORE_DEPTH = CONTROL_MAX * CONTROL_MAX;
  localparam int REPORT_MAX  = 10;

  logic [HEIGHT_W-1:0] control_heights [STORE_DEPTH];
  logic [CFG_W-1:0]    point_count;
  gsu_out_t            expected_heights [$];
  int                  mismatches = 0;
  int                  waiting    = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = waiting;

  // Step i of span along a segment from a to b; falling segments round
  // toward b.
  function automatic int segment_step(int a, int b, int i, int span);
    if (a <= b) return a + (i * (b - a)) / span;
    return a - (i * (a - b) + span - 1) / span;
  endfunction

  // Height on control row crow at fine column fcol.
  function automatic int control_row_height(int crow, int fcol, int span);
    int ccol;
    int off;
    int a;
    ccol = fcol / span;
    off  = fcol % span;
    a    = control_heights[crow * CONTROL_MAX + ccol];
    if (off == 0) return a;
    return segment_step(a, control_heights[crow * CONTROL_MAX + ccol + 1], off, span);
  endfunction

  // Result of one item; a load also updates the control store.
  function automatic gsu_out_t upsample_result(gsu_in_t item);
    gsu_out_t res;
    int       span;
    int       roff;
    int       upper;
    int       value;
    res.height_out = '0;
    res.status     = STATUS_OK;
    if (item.command == CMD_LOAD) begin
      if (item.row >= CONTROL_MAX || item.col >= CONTROL_MAX) begin
        res.status = STATUS_ADDR;
      end else begin
        control_heights[item.row * CONTROL_MAX + item.col] = item.height;
      end
    end else if (item.row > GRID || item.col > GRID) begin
      res.status = STATUS_ADDR;
    end else if (point_count < 2 || point_count > CONTROL_MAX ||
                 (GRID % (int'(point_count) - 1)) != 0) begin
      res.status = STATUS_SPACING;
    end else begin
      span  = GRID / (int'(point_count) - 1);
      roff  = item.row % span;
      upper = control_row_height(item.row / span, item.col, span);
      if (roff == 0) value = upper;
      else value = segment_step(upper,
                                control_row_height(item.row / span + 1, item.col, span),
                                roff, span);
      res.height_out = value[HEIGHT_W-1:0];
    end
    return res;
  endfunction

  task automatic note_mismatch(string what, gsu_out_t want, gsu_out_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s: expected height %0d status %0d, got height %0d status %0d",
               $realtime, what, want.height_out, want.status, got.height_out, got.status);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    gsu_out_t want;
    if (!rst_ni) begin
      point_count = COUNT_RESET;
      expected_heights.delete();
    end else begin
      if (cfg_we_i) point_count = cfg_data_i;
      if (in_valid_i && in_ready_i) expected_heights.push_back(upsample_result(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_heights.size() == 0) begin
          want = '0;
          note_mismatch("result with nothing pending", want, out_data_i);
        end else begin
          want = expected_heights.pop_front();
          if (out_data_i.height_out !== want.height_out || out_data_i.status !== want.status)
            note_mismatch("result mismatch", want, out_data_i);
        end
      end
    end
    waiting = expected_heights.size();
  end

endmodule

### sim/tb_grid_linear_upsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_linear_upsampler
// Drives loads and fine-grid reads into the upsampler under random gaps and
// back-pressure, across several control counts, good and bad; a checker
// beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_grid_linear_upsampler;
  import gsu_pkg::*;

  localparam int GRID        = 40;
  localparam int CONTROL_MAX = 9;
  localparam int ADDR_TOP    = (1 << ROW_W) - 1;   // largest encodable row/col
  localparam int PHASES      = 12;
  localparam int GOOD_ITEMS  = 120;                // items per phase, valid spacing
  localparam int BAD_ITEMS   = 40;                 // items per phase, bad spacing
  localparam int LONG_HOLD   = 400;                // cycles of output back-pressure
  localparam int HOLD_AT     = 300;                // transfer count where it starts
  localparam int TAIL_CYCLES = 100;                // beyond worst-case read latency

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  gsu_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  gsu_out_t         out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               mismatch_count;
  int               pending;

  // Control counts per random phase: extremes, every count whose spacing
  // divides the grid, and a few that do not.
  int phase_counts [PHASES] = '{9, 2, 0, 3, 15, 6, 1, 5, 8, 9, 2, 6};
  int count_setting = COUNT_RESET;                 // our copy of the register
  bit sender_burst  = 1'b0;                        // no gaps while set

  grid_linear_upsampler #(
    .GRID        (GRID),
    .CONTROL_MAX (CONTROL_MAX)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  gsu_height_checker #(
    .GRID        (GRID),
    .CONTROL_MAX (CONTROL_MAX)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  // 4 ns clock
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic gsu_in_t make_item(logic cmd, int frow, int fcol, int h);
    gsu_in_t item;
    item.command = cmd;
    item.row     = frow[ROW_W-1:0];
    item.col     = fcol[COL_W-1:0];
    item.height  = h[HEIGHT_W-1:0];
    return item;
  endfunction

  // Heights lean toward the rails so steep rising and falling segments
  // show up often.
  function automatic int draw_height();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 255 : 0;
    return $urandom_range(0, 255);
  endfunction

  // Offer one item after a random gap and hold it until the transfer.
  // Valid changes only at the falling edge, at most once per step.
  task automatic send_item(gsu_in_t item);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drop valid and wait until every result has come back: block is idle.
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Register write, only ever from an idle block.
  task automatic set_count(int value);
    settle();
    cfg_we        <= 1'b1;
    cfg_data      <= value[CFG_W-1:0];
    count_setting = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // One random item. Most are in-range reads, many landing on control rows
  // or columns; the rest are loads (some out of range) and bad-address reads.
  task automatic random_item();
    int pick;
    int span;
    int frow;
    int fcol;
    pick = $urandom_range(0, 99);
    span = (count_setting >= 2 && count_setting <= CONTROL_MAX &&
            GRID % (count_setting - 1) == 0) ? GRID / (count_setting - 1) : 0;
    if (pick < 12) begin
      send_item(make_item(CMD_LOAD, $urandom_range(0, CONTROL_MAX - 1),
                          $urandom_range(0, CONTROL_MAX - 1), draw_height()));
    end else if (pick < 17) begin
      frow = $urandom_range(CONTROL_MAX, ADDR_TOP);
      fcol = $urandom_range(0, ADDR_TOP);
      if ($urandom_range(0, 1)) send_item(make_item(CMD_LOAD, frow, fcol, draw_height()));
      else send_item(make_item(CMD_LOAD, fcol, frow, draw_height()));
    end else if (pick < 25) begin
      frow = $urandom_range(GRID + 1, ADDR_TOP);
      fcol = $urandom_range(0, ADDR_TOP);
      if ($urandom_range(0, 1)) send_item(make_item(CMD_READ, frow, fcol, draw_height()));
      else send_item(make_item(CMD_READ, fcol, frow, draw_height()));
    end else begin
      frow = (span != 0 && $urandom_range(0, 3) == 0) ?
             span * $urandom_range(0, count_setting - 1) : $urandom_range(0, GRID);
      fcol = (span != 0 && $urandom_range(0, 3) == 0) ?
             span * $urandom_range(0, count_setting - 1) : $urandom_range(0, GRID);
      send_item(make_item(CMD_READ, frow, fcol, $urandom_range(0, 255)));
    end
  endtask

  // Output side: random stall per result, bursts of full rate, and one long
  // hold-off so the job queue fills and in_ready drops.
  initial begin : drain_results
    int stall;
    int taken;
    bit burst;
    out_ready = 1'b0;
    taken     = 0;
    burst     = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (taken % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, 16);
      if (taken == HOLD_AT) stall = LONG_HOLD;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin : stimulus
    int n_items;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset count (span 10). A 2x2 patch of 0/255
    // gives max rising and falling segments in both directions; every read
    // below touches only entries loaded here.
    send_item(make_item(CMD_LOAD, 0, 0, 0));
    send_item(make_item(CMD_LOAD, 0, 1, 255));
    send_item(make_item(CMD_LOAD, 1, 0, 255));
    send_item(make_item(CMD_LOAD, 1, 1, 0));
    send_item(make_item(CMD_LOAD, 4, 4, 255));
    send_item(make_item(CMD_LOAD, CONTROL_MAX - 1, CONTROL_MAX - 1, 8'h5A));
    // loads just past the store and at the field maximum
    send_item(make_item(CMD_LOAD, CONTROL_MAX, 0, 8'h11));
    send_item(make_item(CMD_LOAD, 0, CONTROL_MAX, 8'h22));
    send_item(make_item(CMD_LOAD, ADDR_TOP, ADDR_TOP, 255));
    send_item(make_item(CMD_READ, 0, 0, 0));       // control point
    send_item(make_item(CMD_READ, 0, 10, 0));      // control point
    send_item(make_item(CMD_READ, 0, 1, 0));       // rising, one step
    send_item(make_item(CMD_READ, 0, 5, 0));       // rising, mid segment
    send_item(make_item(CMD_READ, 5, 0, 0));       // vertical, rising
    send_item(make_item(CMD_READ, 5, 5, 0));       // inner point
    send_item(make_item(CMD_READ, 10, 5, 0));      // falling along a row
    send_item(make_item(CMD_READ, 5, 10, 0));      // vertical, falling
    send_item(make_item(CMD_READ, 10, 10, 0));
    send_item(make_item(CMD_READ, GRID, GRID, 255));  // far corner
    send_item(make_item(CMD_READ, GRID + 1, 0, 0));   // just off the grid
    send_item(make_item(CMD_READ, 0, GRID + 1, 0));
    send_item(make_item(CMD_READ, ADDR_TOP, ADDR_TOP, 255));
    // Count 4 leaves span 40/3: spacing error, but address check wins.
    set_count(4);
    send_item(make_item(CMD_READ, 0, 0, 0));
    send_item(make_item(CMD_READ, GRID + 1, GRID, 0));

    // Random phases. The first one loads every control entry, so no later
    // read can touch an entry that was never written.
    for (int p = 0; p < PHASES; p++) begin
      set_count(phase_counts[p]);
      sender_burst = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        for (int r = 0; r < CONTROL_MAX; r++)
          for (int c = 0; c < CONTROL_MAX; c++)
            send_item(make_item(CMD_LOAD, r, c, draw_height()));
      end
      n_items = (count_setting >= 2 && count_setting <= CONTROL_MAX &&
                 GRID % (count_setting - 1) == 0) ? GOOD_ITEMS : BAD_ITEMS;
      for (int i = 0; i < n_items; i++) begin
        if (i % 32 == 0) sender_burst = ($urandom_range(0, 3) == 0);
        random_item();
      end
    end

    // Wait for every result, then a tail for stray outputs.
    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
